### rtl/mlfu_pkg.sv
// ----------------------------------------------------------------------------
// mlfu_pkg
// Shared types and codes of the linear feed-forward network unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfu_pkg;

   localparam int MAX_WIDTH = 32;
   localparam int ACC_W    = 48;
   localparam int SEEN_W   = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 6;

   typedef logic signed [15:0] node_type;
   typedef logic signed [31:0] prod_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_BIAS   = 2'd1;
   localparam logic [1:0] OP_INPUT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIDDEN1     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIDDEN2     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIDDEN3     = 3'd4;

   typedef struct packed {
      logic shift;
      logic copy;
   } cell_ctl_type;

   typedef struct packed {
      logic term;
      logic bias_rd;
      logic bias_ok;
   } mac_ctl_type;

endpackage

`default_nettype wire

### rtl/mlp_linear_forward_unit.sv
// ----------------------------------------------------------------------------
// mlp_linear_forward_unit
// Linear dense network inference in Q8.8 over a ring of node cells.
//
// Request items write a weight (op 0), write a bias (op 1) or deliver an
// input sample (op 2); op 3 is dropped. A sample with last set starts a
// run: if the sample count differs from the input width, one error item
// (status 1) is returned at once. Otherwise every layer is computed node by
// node: the previous layer sits in a ring of MAX_WIDTH cells that rotates
// once per node while one multiply-accumulate takes a weight from memory
// each cycle for each node of the previous layer; the finished layer is
// then copied into the ring. The output layer is returned one item per
// cycle while the receiver does not stall, node 0 first, final_res on the
// last. Requests are refused while a run is active and while the response
// register holds an item that the receiver stalls.
// Reset returns the controller to idle, clears the sample count and sets the
// registers to two layers of width one; the weight and bias memories are
// not cleared and hold undefined values until written.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_linear_forward_unit import mlfu_pkg::*; #(
   parameter int MAX_LAYERS   = 4,
   parameter int WEIGHT_DEPTH = 4096,
   parameter int BIAS_DEPTH   = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [11:0]           req_slot,
   input  node_type              req_value,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output node_type              rsp_node_value,
   output logic [4:0]            rsp_node_number,
   output logic                  rsp_final_res,
   output logic                  rsp_status
);

   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int SW     = $clog2(MAX_WIDTH + 3);
   localparam int S_LAST = MAX_WIDTH + 2;
   localparam int WA     = $clog2(WEIGHT_DEPTH);
   localparam int BA     = $clog2(BIAS_DEPTH);
   localparam int WCW0   = $clog2(3 * MAX_WIDTH * MAX_WIDTH + 1);
   localparam int BCW0   = $clog2(3 * MAX_WIDTH + 1);
   localparam int WCW    = (WCW0 > WA) ? WCW0 : WA;
   localparam int BCW    = (BCW0 > BA) ? BCW0 : BA;
   localparam int SLW    = (WA > 12) ? WA : 12;
   localparam int SLB    = (BA > 12) ? BA : 12;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_COPY = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [2:0]            layer_count_ff;
   logic [CSR_DATA_W-1:0] width_ff [4];
   logic [1:0]            state_ff, state_in;
   logic [SEEN_W-1:0]     seen_ff, seen_in, seen_inc;
   logic [1:0]            layer_ff, layer_in;
   logic [WW-1:0]         node_ff, node_in;
   logic [SW-1:0]         step_ff, step_in;
   logic [WCW-1:0]        wi_ff, wi_in;
   logic [BCW-1:0]        bi_ff, bi_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   node_type              rsp_value_ff, rsp_value_in;
   logic [4:0]            rsp_number_ff, rsp_number_in;
   logic                  rsp_final_ff, rsp_final_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic [WW-1:0]         lw [4];
   logic [2:0]            layers_eff;
   logic [1:0]            last_layer;
   logic [WW-1:0]         prev_w, cur_w;
   logic                  req_fire, rsp_free, emit_fire, node_done, layer_done;
   logic                  sample_fire;
   cell_ctl_type          cell_ctl;
   mac_ctl_type           mac_ctl;
   node_type              ring [MAX_WIDTH];
   logic [MAX_WIDTH-1:0]  load_en, store_en;
   node_type              mac_result;
   logic [SLW-1:0]        slot_w;
   logic [SLB-1:0]        slot_b;

   function automatic logic [WW-1:0] clamp_width(input logic [CSR_DATA_W-1:0] w);
      logic [WW-1:0] r;
      if (w == '0) begin
         r = WW'(1);
      end else if (int'(w) > MAX_WIDTH) begin
         r = WW'(MAX_WIDTH);
      end else begin
         r = WW'(w);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= 3'd2;
         for (int i = 0; i < 4; i++) begin
            width_ff[i] <= CSR_DATA_W'(1);
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_LAYER_COUNT: layer_count_ff <= csr_wdata[2:0];
            CSR_INPUT_WIDTH: width_ff[0] <= csr_wdata;
            CSR_HIDDEN1:     width_ff[1] <= csr_wdata;
            CSR_HIDDEN2:     width_ff[2] <= csr_wdata;
            CSR_HIDDEN3:     width_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lw[i] = clamp_width(width_ff[i]);
      end
      if (layer_count_ff < 3'd2) begin
         layers_eff = 3'd2;
      end else if (int'(layer_count_ff) > MAX_LAYERS) begin
         layers_eff = 3'(MAX_LAYERS);
      end else begin
         layers_eff = layer_count_ff;
      end
      if (layers_eff > 3'd4) begin
         layers_eff = 3'd4;
      end
      last_layer = 2'(layers_eff - 3'd1);
      prev_w     = lw[layer_ff - 2'd1];
      cur_w      = lw[layer_ff];
   end

   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire    = req_valid && req_ready;
   assign sample_fire = req_fire && (req_op == OP_INPUT);
   assign emit_fire   = (state_ff == ST_EMIT) && rsp_free;
   assign node_done   = (state_ff == ST_RUN) && (int'(step_ff) == S_LAST);
   assign layer_done  = node_done && (node_ff == cur_w - WW'(1));
   assign seen_inc    = (seen_ff == '1) ? seen_ff : seen_ff + SEEN_W'(1);

   always_comb begin
      cell_ctl.shift = ((state_ff == ST_RUN) && (int'(step_ff) < MAX_WIDTH)) || emit_fire;
      cell_ctl.copy  = (state_ff == ST_COPY);
      mac_ctl.term   = (state_ff == ST_RUN) && ({1'b0, step_ff} < (SW+1)'(prev_w))
                       && (int'(wi_ff) < WEIGHT_DEPTH);
      mac_ctl.bias_rd = (state_ff == ST_RUN) && (step_ff == '0);
      mac_ctl.bias_ok = (int'(bi_ff) < BIAS_DEPTH);
      for (int i = 0; i < MAX_WIDTH; i++) begin
         load_en[i]  = sample_fire && (int'(seen_ff) == i);
         store_en[i] = node_done && (int'(node_ff) == i);
      end
   end

   always_comb begin
      state_in      = state_ff;
      seen_in       = seen_ff;
      layer_in      = layer_ff;
      node_in       = node_ff;
      step_in       = step_ff;
      wi_in         = wi_ff;
      bi_in         = bi_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_number_in = rsp_number_ff;
      rsp_final_in  = rsp_final_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sample_fire) begin
               seen_in = seen_inc;
               if (req_last) begin
                  seen_in = '0;
                  if (seen_inc != SEEN_W'(lw[0])) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_number_in = '0;
                     rsp_final_in  = 1'b1;
                     rsp_status_in = 1'b1;
                  end else begin
                     state_in = ST_RUN;
                     layer_in = 2'd1;
                     node_in  = '0;
                     step_in  = '0;
                     wi_in    = '0;
                     bi_in    = '0;
                  end
               end
            end
         end
         ST_RUN: begin
            step_in = step_ff + SW'(1);
            if ({1'b0, step_ff} < (SW+1)'(prev_w)) begin
               wi_in = wi_ff + WCW'(1);
            end
            if (step_ff == '0) begin
               bi_in = bi_ff + BCW'(1);
            end
            if (node_done) begin
               step_in = '0;
               node_in = node_ff + WW'(1);
               if (layer_done) begin
                  state_in = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            node_in = '0;
            if (layer_ff == last_layer) begin
               state_in = ST_EMIT;
            end else begin
               layer_in = layer_ff + 2'd1;
               state_in = ST_RUN;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = ring[0];
               rsp_number_in = 5'(node_ff);
               rsp_final_in  = (node_ff == cur_w - WW'(1));
               rsp_status_in = 1'b0;
               node_in       = node_ff + WW'(1);
               if (node_ff == cur_w - WW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      layer_ff      <= layer_in;
      node_ff       <= node_in;
      step_ff       <= step_in;
      wi_ff         <= wi_in;
      bi_ff         <= bi_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_number_ff <= rsp_number_in;
      rsp_final_ff  <= rsp_final_in;
      rsp_status_ff <= rsp_status_in;
   end

   for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_cell
      mlfu_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .load_en   (load_en[g]),
         .store_en  (store_en[g]),
         .load_val  (req_value),
         .store_val (mac_result),
         .shift_in  (ring[(g + 1) % MAX_WIDTH]),
         .node      (ring[g])
      );
   end

   assign slot_w = SLW'(req_slot);
   assign slot_b = SLB'(req_slot);

   mlfu_mac #(
      .WEIGHT_DEPTH (WEIGHT_DEPTH),
      .BIAS_DEPTH   (BIAS_DEPTH)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .wt_we      (req_fire && (req_op == OP_WEIGHT) && (int'(req_slot) < WEIGHT_DEPTH)),
      .bs_we      (req_fire && (req_op == OP_BIAS) && (int'(req_slot) < BIAS_DEPTH)),
      .wt_wr_addr (slot_w[WA-1:0]),
      .bs_wr_addr (slot_b[BA-1:0]),
      .wr_data    (req_value),
      .wt_rd_addr (wi_ff[WA-1:0]),
      .bs_rd_addr (bi_ff[BA-1:0]),
      .ctl        (mac_ctl),
      .node_in    (ring[0]),
      .result     (mac_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_value  = rsp_value_ff;
   assign rsp_node_number = rsp_number_ff;
   assign rsp_final_res   = rsp_final_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/mlfu_cell.sv
// ----------------------------------------------------------------------------
// mlfu_cell
// One node cell: a ring register for the previous layer and a staging
// register for the layer under computation.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfu_cell import mlfu_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         load_en,
   input  logic         store_en,
   input  node_type     load_val,
   input  node_type     store_val,
   input  node_type     shift_in,
   output node_type     node
);

   node_type node_ff;
   node_type next_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         node_ff <= load_val;
      end else if (ctl.copy) begin
         node_ff <= next_ff;
      end else if (ctl.shift) begin
         node_ff <= shift_in;
      end
      if (store_en) begin
         next_ff <= store_val;
      end
   end

   assign node = node_ff;

endmodule

`default_nettype wire

### rtl/mlfu_mac.sv
// ----------------------------------------------------------------------------
// mlfu_mac
// Weight and bias memories with a pipelined multiply-accumulate and the
// Q8.8 round and saturate of the finished sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfu_mac import mlfu_pkg::*; #(
   parameter int WEIGHT_DEPTH = 4096,
   parameter int BIAS_DEPTH   = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wt_we,
   input  logic                            bs_we,
   input  logic [$clog2(WEIGHT_DEPTH)-1:0] wt_wr_addr,
   input  logic [$clog2(BIAS_DEPTH)-1:0]   bs_wr_addr,
   input  node_type                        wr_data,
   input  logic [$clog2(WEIGHT_DEPTH)-1:0] wt_rd_addr,
   input  logic [$clog2(BIAS_DEPTH)-1:0]   bs_rd_addr,
   input  mac_ctl_type                     ctl,
   input  node_type                        node_in,
   output node_type                        result
);

   localparam acc_type Q_MAX = acc_type'(32767);
   localparam acc_type Q_MIN = -acc_type'(32768);

   node_type weight_mem [WEIGHT_DEPTH];
   node_type bias_mem [BIAS_DEPTH];

   node_type wt_rd_ff;
   node_type bs_rd_ff;
   node_type a_node_ff;
   logic     a_v_ff;
   logic     b_rd_ff;
   logic     b_ok_ff;
   prod_type prod_ff;
   logic     p_v_ff;
   acc_type  acc_ff;
   acc_type  acc_in;
   acc_type  rounded;
   acc_type  quot;

   always_ff @(posedge clock) begin
      if (wt_we) begin
         weight_mem[wt_wr_addr] <= wr_data;
      end
      if (bs_we) begin
         bias_mem[bs_wr_addr] <= wr_data;
      end
      wt_rd_ff  <= weight_mem[wt_rd_addr];
      bs_rd_ff  <= bias_mem[bs_rd_addr];
      a_node_ff <= node_in;
      b_ok_ff   <= ctl.bias_ok;
      prod_ff   <= wt_rd_ff * a_node_ff;
      acc_ff    <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff  <= 1'b0;
         b_rd_ff <= 1'b0;
         p_v_ff  <= 1'b0;
      end else begin
         a_v_ff  <= ctl.term;
         b_rd_ff <= ctl.bias_rd;
         p_v_ff  <= a_v_ff;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (b_rd_ff) begin
         acc_in = b_ok_ff ? {{(ACC_W-24){bs_rd_ff[15]}}, bs_rd_ff, 8'd0} : '0;
      end else if (p_v_ff) begin
         acc_in = acc_ff + {{(ACC_W-32){prod_ff[31]}}, prod_ff};
      end
   end

   always_comb begin
      rounded = acc_ff + acc_type'(128);
      quot    = rounded >>> 8;
      if (quot > Q_MAX) begin
         result = 16'sh7fff;
      end else if (quot < Q_MIN) begin
         result = 16'sh8000;
      end else begin
         result = quot[15:0];
      end
   end

endmodule

`default_nettype wire

### rtl/mlfu_checker.sv
// ----------------------------------------------------------------------------
// mlfu_checker
// Port-level checks of the network unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfu_checker import mlfu_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input node_type   rsp_node_value,
   input logic [4:0] rsp_node_number,
   input logic       rsp_final_res,
   input logic       rsp_status
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_node_value)
         && $stable(rsp_node_number) && $stable(rsp_final_res))
      else $error("stalled response changed");

   a_error_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_final_res && rsp_node_value == 0
         && rsp_node_number == 0)
      else $error("malformed error item");

   a_emit_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final_res |=> rsp_valid && !rsp_status)
      else $error("gap in output layer items");

endmodule

bind mlp_linear_forward_unit mlfu_checker u_mlfu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_node_value  (rsp_node_value),
   .rsp_node_number (rsp_node_number),
   .rsp_final_res   (rsp_final_res),
   .rsp_status      (rsp_status)
);

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear feed-forward network unit.
//
// Weights, biases and samples go in as request items. A bench-side copy of
// the network computes the Q8.8 output layer, or the count error, for every
// last sample. Each response item is checked against the oldest prediction.
// Directed tests cover the reset defaults, the size extremes, register
// saturation, count errors, dropped ops and a drain pause. A random part
// follows; both channels stall at random until late in the random part.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import mlfu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 1000000;

   typedef struct {
      node_type   value;
      logic [4:0] number;
      logic       final_res;
      logic       status;
   } node_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_op = OP_WEIGHT;
   logic [11:0]           req_slot = '0;
   node_type              req_value = '0;
   logic                  req_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   node_type              rsp_node_value;
   logic [4:0]            rsp_node_number;
   logic                  rsp_final_res;
   logic                  rsp_status;

   node_type        weight_mem [0:4095];
   node_type        bias_mem [0:127];
   node_type        node_mem [0:127];
   int unsigned     samples_seen;
   int unsigned     cfg_layers, cfg_in, cfg_h1, cfg_h2, cfg_h3;
   node_result_type node_results [$];

   int  errors = 0;
   int  cycles = 0;
   int  items_sent = 0;
   bit  quiet = 1'b0;
   int  stall_left = 0;

   mlp_linear_forward_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_slot(req_slot), .req_value(req_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_node_value(rsp_node_value), .rsp_node_number(rsp_node_number),
      .rsp_final_res(rsp_final_res), .rsp_status(rsp_status)
   );

   always #10 clock = ~clock;

   function automatic int unsigned clamp_width(int unsigned w);
      if (w < 1) return 1;
      if (w > 32) return 32;
      return w;
   endfunction

   function automatic int unsigned layer_width(int unsigned l);
      case (l)
         0: return clamp_width(cfg_in);
         1: return clamp_width(cfg_h1);
         2: return clamp_width(cfg_h2);
         default: return clamp_width(cfg_h3);
      endcase
   endfunction

   function automatic int unsigned layer_total();
      if (cfg_layers < 2) return 2;
      if (cfg_layers > 4) return 4;
      return cfg_layers;
   endfunction

   function automatic node_type round_q88(longint acc);
      longint q;
      q = (acc + 128) >>> 8;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return node_type'(q);
   endfunction

   function automatic void run_network();
      int unsigned wi, bi, prev_off, prev_w, cur_w;
      longint acc;
      node_result_type r;
      wi = 0;
      bi = 0;
      prev_off = 0;
      cur_w = layer_width(0);
      for (int unsigned l = 1; l < layer_total(); l++) begin
         prev_w = layer_width(l - 1);
         cur_w = layer_width(l);
         for (int unsigned j = 0; j < cur_w; j++) begin
            acc = longint'(bias_mem[bi]) * 256;
            bi++;
            for (int unsigned k = 0; k < prev_w; k++) begin
               acc += longint'(weight_mem[wi]) * longint'(node_mem[prev_off + k]);
               wi++;
            end
            node_mem[prev_off + prev_w + j] = round_q88(acc);
         end
         prev_off += prev_w;
      end
      for (int unsigned j = 0; j < cur_w; j++) begin
         r.value = node_mem[prev_off + j];
         r.number = j[4:0];
         r.final_res = (j + 1 == cur_w);
         r.status = 1'b0;
         node_results.push_back(r);
      end
   endfunction

   function automatic void track_item(logic [1:0] op, logic [11:0] slot, node_type val,
                                      logic last);
      int unsigned count;
      node_result_type r;
      if (op == OP_WEIGHT) begin
         weight_mem[slot] = val;
      end else if (op == OP_BIAS) begin
         if (slot < 128) bias_mem[slot] = val;
      end else if (op == OP_INPUT) begin
         if (samples_seen < 32) node_mem[samples_seen] = val;
         if (samples_seen < 63) samples_seen++;
         if (last) begin
            count = samples_seen;
            samples_seen = 0;
            if (count != layer_width(0)) begin
               r.value = '0;
               r.number = '0;
               r.final_res = 1'b1;
               r.status = 1'b1;
               node_results.push_back(r);
            end else begin
               run_network();
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && req_valid && req_ready)
         track_item(req_op, req_slot, req_value, req_last);
      if (!reset && rsp_valid && rsp_ready) begin
         if (node_results.size() == 0) begin
            $error("unexpected result item: node_value %0d node_number %0d",
                   rsp_node_value, rsp_node_number);
            errors++;
         end else begin
            node_result_type e;
            e = node_results.pop_front();
            if (rsp_node_value !== e.value) begin
               $error("node_value: expected %0d, got %0d", e.value, rsp_node_value);
               errors++;
            end
            if (rsp_node_number !== e.number) begin
               $error("node_number: expected %0d, got %0d", e.number, rsp_node_number);
               errors++;
            end
            if (rsp_final_res !== e.final_res) begin
               $error("final_res: expected %0b, got %0b", e.final_res, rsp_final_res);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status: expected %0b, got %0b", e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (quiet) begin
         rsp_ready = 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready = 1'b0;
         stall_left = $urandom_range(0, 15);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   function automatic node_type pick_value();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return node_type'(int'($urandom_range(0, 1023)) - 512);
         default: return node_type'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [11:0] slot,
                            input node_type val, input logic last);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_slot = slot;
      req_value = val;
      req_last = last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      wait (node_results.size() == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_LAYER_COUNT: cfg_layers = val & 7;
         CSR_INPUT_WIDTH: cfg_in = val & 63;
         CSR_HIDDEN1:     cfg_h1 = val & 63;
         CSR_HIDDEN2:     cfg_h2 = val & 63;
         default:         cfg_h3 = val & 63;
      endcase
   endtask

   task automatic configure(input int unsigned lc, input int unsigned w0,
                            input int unsigned w1, input int unsigned w2,
                            input int unsigned w3);
      drain();
      write_csr(CSR_LAYER_COUNT, lc);
      write_csr(CSR_INPUT_WIDTH, w0);
      write_csr(CSR_HIDDEN1, w1);
      write_csr(CSR_HIDDEN2, w2);
      write_csr(CSR_HIDDEN3, w3);
   endtask

   task automatic load_parameters();
      int unsigned nw, nb;
      nw = 0;
      nb = 0;
      for (int unsigned l = 1; l < layer_total(); l++) begin
         nw += layer_width(l - 1) * layer_width(l);
         nb += layer_width(l);
      end
      for (int unsigned i = 0; i < nw; i++)
         send_item(OP_WEIGHT, i[11:0], pick_value(), 1'($urandom));
      for (int unsigned i = 0; i < nb; i++)
         send_item(OP_BIAS, i[11:0], pick_value(), 1'($urandom));
   endtask

   task automatic send_samples(input int unsigned n, input bit noisy);
      for (int unsigned i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0: send_item(2'd3, 12'($urandom), node_type'($urandom), 1'($urandom));
               1: send_item(OP_BIAS, 12'($urandom_range(128, 4095)), pick_value(),
                            1'($urandom));
               default: send_item(OP_WEIGHT, 12'($urandom), pick_value(),
                                  1'($urandom));
            endcase
         end
         send_item(OP_INPUT, 12'($urandom), pick_value(), i + 1 == n);
      end
   endtask

   task automatic test_reset_defaults();
      cfg_layers = 2;
      cfg_in = 1;
      cfg_h1 = 1;
      cfg_h2 = 1;
      cfg_h3 = 1;
      send_item(OP_WEIGHT, 12'd0, 16'sh0100, 1'b1);
      send_item(OP_BIAS, 12'd0, 16'sh0080, 1'b0);
      send_samples(1, 0);
      send_samples(2, 0);
   endtask

   task automatic test_size_extremes();
      configure(4, 32, 1, 1, 32);
      load_parameters();
      send_samples(32, 0);
      configure(3, 1, 32, 1, 1);
      load_parameters();
      send_samples(1, 0);
   endtask

   task automatic test_register_saturation();
      configure(0, 0, 0, 0, 0);
      load_parameters();
      send_samples(1, 0);
      configure(7, 2, 1, 1, 63);
      load_parameters();
      send_samples(2, 0);
      configure(5, 2, 0, 1, 1);
      load_parameters();
      send_samples(2, 0);
   endtask

   task automatic test_count_errors();
      configure(2, 3, 2, 1, 1);
      load_parameters();
      send_samples(1, 0);
      send_samples(4, 0);
      send_samples(66, 0);
      send_samples(3, 0);
   endtask

   task automatic test_dropped_ops();
      send_item(2'd3, 12'hfff, 16'sh7fff, 1'b1);
      send_item(OP_BIAS, 12'hfff, 16'sh8000, 1'b1);
      send_item(OP_BIAS, 12'd128, 16'sh1234, 1'b0);
      send_item(OP_WEIGHT, 12'hfff, 16'sh5555, 1'b1);
      send_samples(3, 0);
   endtask

   task automatic test_drain_pause();
      send_samples(3, 0);
      drain();
      send_samples(3, 0);
   endtask

   task automatic test_random(input int unsigned target);
      int unsigned start, w, n;
      start = items_sent;
      while (items_sent - start < target) begin
         if ($urandom_range(0, 9) == 0)
            configure($urandom_range(0, 7), $urandom_range(0, 6), $urandom_range(0, 6),
                      $urandom_range(0, 6), $urandom_range(0, 6));
         else
            configure($urandom_range(2, 4), $urandom_range(1, 6), $urandom_range(1, 6),
                      $urandom_range(1, 6), $urandom_range(1, 6));
         load_parameters();
         w = layer_width(0);
         repeat ($urandom_range(2, 5)) begin
            n = w;
            if ($urandom_range(0, 6) == 0) begin
               n = $urandom_range(1, w + 3);
               if (n == w) n = w + 1;
            end
            send_samples(n, 1);
         end
         if (items_sent - start > target * 3 / 4) quiet = 1'b1;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_size_extremes();
      test_register_saturation();
      test_count_errors();
      test_dropped_ops();
      test_drain_pause();
      test_random(60);
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
